/* hw/rtl/dvrt_pkg.sv */
// Shared types and constants of the distance-vector route table unit.
package dvrt_pkg;

    // Request codes carried in the input tuser field
    typedef enum logic [2:0] {
        ACT_INIT   = 3'd0,
        ACT_ADD    = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_LOOKUP = 3'd3,
        ACT_FWD    = 3'd4,
        ACT_AGE    = 3'd5
    } t_action;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // Age at which an entry expires
    localparam logic [2:0] AGE_LIMIT = 3'd3;

    localparam int NODE_W = 16;
    localparam int LIVE_W = 6;

    // One table entry as stored in the RAM
    typedef struct packed {
        logic [NODE_W-1:0] dest;
        logic [NODE_W-1:0] hop;
        logic [NODE_W-1:0] cost;
        logic [1:0]        age;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Read address source
    typedef enum logic [1:0] {
        RD_PTR,
        RD_NEXT,
        RD_LAST
    } t_rd_sel;

    // Write address and data source
    typedef enum logic [2:0] {
        WR_INIT,
        WR_APPEND,
        WR_UPD,
        WR_AGE,
        WR_MOVE
    } t_wr_sel;

    // Result source
    typedef enum logic [2:0] {
        RES_OK,
        RES_FULL,
        RES_NF,
        RES_HOP_RD,
        RES_HOP_SELF,
        RES_LIVE
    } t_res_sel;

    // Controller state
    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_SRCH,
        S_AGE_RD,
        S_AGE_EX,
        S_AGE_MV,
        S_DONE
    } t_state;

    // Commands from controller to datapath
    typedef struct packed {
        logic     req_load;
        logic     rd_en;
        t_rd_sel  rd_sel;
        logic     wr_en;
        t_wr_sel  wr_sel;
        logic     ptr_clr;
        logic     ptr_inc;
        logic     cnt_set1;
        logic     cnt_inc;
        logic     cnt_dec;
        logic     live_clr;
        logic     live_inc;
        logic     res_load;
        t_res_sel res_sel;
        logic     out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_action action;
        logic    fwd_self;
        logic    full;
        logic    ptr_end;
        logic    next_end;
        logic    match;
        logic    cost_lt;
        logic    self_hit;
        logic    expire;
        logic    out_free;
    } t_dp_status;

endpackage

/* hw/rtl/dvrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dvrt_ram #(
    parameter int W = 8,
    parameter int D = 32,
    localparam int AW = $clog2(D)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [W-1:0]  i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [W-1:0]  o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, hold data when not reading
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/dvrt_dp.sv */
// Datapath: request and config registers, entry RAM, scan pointer, count and result registers.
module dvrt_dp #(
    parameter int TABLE_DEPTH = 32,
    localparam int AW = $clog2(TABLE_DEPTH),
    localparam int CW = $clog2(TABLE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [2:0]           i_req_action,
    input  logic [47:0]          i_req_data,
    input  logic                 i_cfg_we,
    input  logic [15:0]          i_cfg_data,
    input  dvrt_pkg::t_dp_cmd    i_cmd,
    output dvrt_pkg::t_dp_status o_status,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output logic [1:0]           o_out_status,
    output logic [15:0]          o_out_hop,
    output logic [5:0]           o_out_live
);

    // Request registers
    dvrt_pkg::t_action r_action;
    logic [15:0]       r_node;
    logic [15:0]       r_via;
    logic [15:0]       r_cost;
    logic [15:0]       r_self;

    // Table control
    logic [CW-1:0] r_count;
    logic          r_e0_valid;
    logic [CW-1:0] r_ptr;
    logic [AW-1:0] r_last_addr;
    logic          r_pend;
    logic [CW-1:0] r_live;

    // Result staging and output registers
    logic [1:0]  r_res_status;
    logic [15:0] r_res_hop;
    logic [5:0]  r_res_live;
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [15:0] r_out_hop;
    logic [5:0]  r_out_live;

    logic [CW:0]   w_ptr_inc;
    logic [CW-1:0] w_cnt_dec;
    logic [AW-1:0] w_raddr;
    logic [AW-1:0] w_waddr;
    dvrt_pkg::t_entry w_wdata;
    dvrt_pkg::t_entry w_ram_rdata;
    dvrt_pkg::t_entry w_rd;
    logic [2:0]    w_age_inc;

    assign w_ptr_inc = {1'b0, r_ptr} + {{CW{1'b0}}, 1'b1};
    assign w_cnt_dec = r_count - {{(CW-1){1'b0}}, 1'b1};
    assign w_age_inc = {1'b0, w_rd.age} + 3'd1;

    // Entry 0 reads as zero until it is first written
    assign w_rd = (r_last_addr == '0 && !r_e0_valid) ? '0 : w_ram_rdata;

    // Select read address
    always_comb begin
        case (i_cmd.rd_sel)
            dvrt_pkg::RD_PTR:  w_raddr = r_ptr[AW-1:0];
            dvrt_pkg::RD_NEXT: w_raddr = w_ptr_inc[AW-1:0];
            dvrt_pkg::RD_LAST: w_raddr = w_cnt_dec[AW-1:0];
            default:           w_raddr = r_ptr[AW-1:0];
        endcase
    end

    // Select write address and entry
    always_comb begin
        case (i_cmd.wr_sel)
            dvrt_pkg::WR_INIT: begin
                w_waddr = '0;
                w_wdata = '{dest: r_self, hop: r_self, cost: '0, age: '0};
            end
            dvrt_pkg::WR_APPEND: begin
                w_waddr = r_count[AW-1:0];
                w_wdata = '{dest: r_node,
                            hop:  (r_action == dvrt_pkg::ACT_ADD) ? r_node : r_via,
                            cost: r_cost, age: '0};
            end
            dvrt_pkg::WR_UPD: begin
                w_waddr = r_last_addr;
                w_wdata = '{dest: r_node, hop: r_via, cost: r_cost, age: '0};
            end
            dvrt_pkg::WR_AGE: begin
                w_waddr = r_ptr[AW-1:0];
                w_wdata = '{dest: w_rd.dest, hop: w_rd.hop, cost: w_rd.cost,
                            age: w_age_inc[1:0]};
            end
            dvrt_pkg::WR_MOVE: begin
                w_waddr = r_ptr[AW-1:0];
                w_wdata = w_rd;
            end
            default: begin
                w_waddr = r_ptr[AW-1:0];
                w_wdata = w_rd;
            end
        endcase
    end

    dvrt_ram #(
        .W (dvrt_pkg::ENTRY_W),
        .D (TABLE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Report status to the controller
    always_comb begin
        o_status.action   = r_action;
        o_status.fwd_self = (r_node == r_self);
        o_status.full     = (r_count >= CW'(TABLE_DEPTH));
        o_status.ptr_end  = (r_ptr >= r_count);
        o_status.next_end = (w_ptr_inc >= {1'b0, r_count});
        o_status.match    = r_pend && (w_rd.dest == r_node);
        o_status.cost_lt  = (r_cost < w_rd.cost);
        o_status.self_hit = (w_rd.dest == r_self);
        o_status.expire   = (w_age_inc >= dvrt_pkg::AGE_LIMIT);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    // Capture request payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.req_load) begin
            r_action <= dvrt_pkg::t_action'(i_req_action);
            r_node   <= i_req_data[15:0];
            r_via    <= i_req_data[31:16];
            r_cost   <= i_req_data[47:32];
        end
    end

    // Hold self node address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self <= '0;
        end else if (i_cfg_we) begin
            r_self <= i_cfg_data;
        end
    end

    // Advance count, pointer and entry 0 flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= CW'(1);
            r_e0_valid <= 1'b0;
            r_ptr      <= '0;
            r_last_addr <= '0;
            r_pend     <= 1'b0;
            r_live     <= '0;
        end else begin
            r_pend <= i_cmd.rd_en;
            if (i_cmd.rd_en) begin
                r_last_addr <= w_raddr;
            end
            if (i_cmd.wr_en && w_waddr == '0) begin
                r_e0_valid <= 1'b1;
            end
            if (i_cmd.cnt_set1) begin
                r_count <= CW'(1);
            end else if (i_cmd.cnt_inc) begin
                r_count <= r_count + {{(CW-1){1'b0}}, 1'b1};
            end else if (i_cmd.cnt_dec) begin
                r_count <= w_cnt_dec;
            end
            if (i_cmd.ptr_clr) begin
                r_ptr <= '0;
            end else if (i_cmd.ptr_inc) begin
                r_ptr <= w_ptr_inc[CW-1:0];
            end
            if (i_cmd.live_clr) begin
                r_live <= '0;
            end else if (i_cmd.live_inc) begin
                r_live <= r_live + {{(CW-1){1'b0}}, 1'b1};
            end
        end
    end

    // Stage the result
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_load) begin
            r_res_status <= dvrt_pkg::ST_OK;
            r_res_hop    <= '0;
            r_res_live   <= '0;
            case (i_cmd.res_sel)
                dvrt_pkg::RES_OK:       r_res_status <= dvrt_pkg::ST_OK;
                dvrt_pkg::RES_FULL:     r_res_status <= dvrt_pkg::ST_FULL;
                dvrt_pkg::RES_NF:       r_res_status <= dvrt_pkg::ST_NOT_FOUND;
                dvrt_pkg::RES_HOP_RD:   r_res_hop    <= w_rd.hop;
                dvrt_pkg::RES_HOP_SELF: r_res_hop    <= r_self;
                dvrt_pkg::RES_LIVE:     r_res_live   <= dvrt_pkg::LIVE_W'(r_live);
                default:                r_res_status <= dvrt_pkg::ST_OK;
            endcase
        end
    end

    // Output register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_hop    <= r_res_hop;
            r_out_live   <= r_res_live;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_hop    = r_out_hop;
    assign o_out_live   = r_out_live;

endmodule

/* hw/rtl/dvrt_ctrl.sv */
// Controller: sequences each request through search, append, update and aging walk.
module dvrt_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  dvrt_pkg::t_dp_status i_status,
    output dvrt_pkg::t_dp_cmd    o_cmd
);

    dvrt_pkg::t_state r_state;
    dvrt_pkg::t_state n_state;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dvrt_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dvrt_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.req_load = 1'b1;
                    n_state        = dvrt_pkg::S_DISPATCH;
                end
            end

            dvrt_pkg::S_DISPATCH: begin
                n_state = dvrt_pkg::S_DONE;
                case (i_status.action)
                    dvrt_pkg::ACT_INIT: begin
                        o_cmd.wr_en    = 1'b1;
                        o_cmd.wr_sel   = dvrt_pkg::WR_INIT;
                        o_cmd.cnt_set1 = 1'b1;
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = dvrt_pkg::RES_OK;
                    end
                    dvrt_pkg::ACT_ADD: begin
                        o_cmd.res_load = 1'b1;
                        if (i_status.full) begin
                            o_cmd.res_sel = dvrt_pkg::RES_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = dvrt_pkg::WR_APPEND;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.res_sel = dvrt_pkg::RES_OK;
                        end
                    end
                    dvrt_pkg::ACT_UPDATE, dvrt_pkg::ACT_LOOKUP: begin
                        o_cmd.ptr_clr = 1'b1;
                        n_state       = dvrt_pkg::S_SRCH;
                    end
                    dvrt_pkg::ACT_FWD: begin
                        if (i_status.fwd_self) begin
                            o_cmd.res_load = 1'b1;
                            o_cmd.res_sel  = dvrt_pkg::RES_HOP_SELF;
                        end else begin
                            o_cmd.ptr_clr = 1'b1;
                            n_state       = dvrt_pkg::S_SRCH;
                        end
                    end
                    dvrt_pkg::ACT_AGE: begin
                        o_cmd.ptr_clr  = 1'b1;
                        o_cmd.live_clr = 1'b1;
                        n_state        = dvrt_pkg::S_AGE_RD;
                    end
                    default: begin
                        o_cmd.res_load = 1'b1;
                        o_cmd.res_sel  = dvrt_pkg::RES_OK;
                    end
                endcase
            end

            // Scan entries in order, one read issued per cycle
            dvrt_pkg::S_SRCH: begin
                if (i_status.match) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = dvrt_pkg::S_DONE;
                    if (i_status.action == dvrt_pkg::ACT_UPDATE) begin
                        o_cmd.res_sel = dvrt_pkg::RES_OK;
                        if (i_status.cost_lt) begin
                            o_cmd.wr_en  = 1'b1;
                            o_cmd.wr_sel = dvrt_pkg::WR_UPD;
                        end
                    end else begin
                        o_cmd.res_sel = dvrt_pkg::RES_HOP_RD;
                    end
                end else if (i_status.ptr_end) begin
                    o_cmd.res_load = 1'b1;
                    n_state        = dvrt_pkg::S_DONE;
                    if (i_status.action == dvrt_pkg::ACT_UPDATE) begin
                        if (i_status.full) begin
                            o_cmd.res_sel = dvrt_pkg::RES_FULL;
                        end else begin
                            o_cmd.wr_en   = 1'b1;
                            o_cmd.wr_sel  = dvrt_pkg::WR_APPEND;
                            o_cmd.cnt_inc = 1'b1;
                            o_cmd.res_sel = dvrt_pkg::RES_OK;
                        end
                    end else begin
                        o_cmd.res_sel = dvrt_pkg::RES_NF;
                    end
                end else begin
                    o_cmd.rd_en   = 1'b1;
                    o_cmd.rd_sel  = dvrt_pkg::RD_PTR;
                    o_cmd.ptr_inc = 1'b1;
                end
            end

            // Fetch the slot under the pointer or finish the walk
            dvrt_pkg::S_AGE_RD: begin
                if (i_status.ptr_end) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = dvrt_pkg::RES_LIVE;
                    n_state        = dvrt_pkg::S_DONE;
                end else begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = dvrt_pkg::RD_PTR;
                    n_state      = dvrt_pkg::S_AGE_EX;
                end
            end

            // Examine one slot: keep, age, or start removal
            dvrt_pkg::S_AGE_EX: begin
                if (!i_status.self_hit && i_status.expire) begin
                    o_cmd.rd_en  = 1'b1;
                    o_cmd.rd_sel = dvrt_pkg::RD_LAST;
                    n_state      = dvrt_pkg::S_AGE_MV;
                end else begin
                    if (!i_status.self_hit) begin
                        o_cmd.wr_en  = 1'b1;
                        o_cmd.wr_sel = dvrt_pkg::WR_AGE;
                    end
                    o_cmd.live_inc = 1'b1;
                    o_cmd.ptr_inc  = 1'b1;
                    // Finish through the read state so the live count includes this slot
                    if (i_status.next_end) begin
                        n_state = dvrt_pkg::S_AGE_RD;
                    end else begin
                        o_cmd.rd_en  = 1'b1;
                        o_cmd.rd_sel = dvrt_pkg::RD_NEXT;
                    end
                end
            end

            // Move the last entry into the expired slot, then re-examine it
            dvrt_pkg::S_AGE_MV: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wr_sel  = dvrt_pkg::WR_MOVE;
                o_cmd.cnt_dec = 1'b1;
                n_state       = dvrt_pkg::S_AGE_RD;
            end

            // Hand the result to the output register once it is free
            dvrt_pkg::S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dvrt_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = dvrt_pkg::S_IDLE;
            end
        endcase
    end

endmodule

/* hw/rtl/distance_vector_route_table_unit.sv */
// Init, add, forward to self and unused codes finish in the dispatch state, without a table scan.
// Lookup and update scan the entries in order, one RAM read per cycle.
// Age examines each entry in turn and replaces an expired one with the last entry.
// One request in flight; the next is taken the cycle after the result enters the output
// register, which waits there while the result side stalls. Reset: synchronous, active low;
// table holds the self entry (all zero), count 1, self node 0.
module distance_vector_route_table_unit #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // node [15:0], via_node [31:16], route_cost [47:32]
    input  logic [2:0]  s_axis_tuser,   // action [2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // hop_out [15:0], live_count [21:16], zero [23:22]
    output logic [1:0]  m_axis_tuser,   // status [1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    dvrt_pkg::t_dp_cmd    w_cmd;
    dvrt_pkg::t_dp_status w_status;
    logic [15:0]          w_hop;
    logic [5:0]           w_live;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    dvrt_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    dvrt_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_action (s_axis_tuser),
        .i_req_data   (s_axis_tdata),
        .i_cfg_we     (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_cmd        (w_cmd),
        .o_status     (w_status),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_status (m_axis_tuser),
        .o_out_hop    (w_hop),
        .o_out_live   (w_live)
    );

    // Pack result fields
    assign m_axis_tdata = {2'b00, w_live, w_hop};

endmodule
